// File: hdl/brs_pkg.sv
package brs_pkg;

    localparam int FIELD_BITS = 6;
    localparam int HIST_BITS  = 16;

    localparam logic [HIST_BITS-1:0] HIST_ONES    = 16'hFFFF;
    localparam logic [HIST_BITS-1:0] HIST_ZEROS   = 16'h0000;
    localparam logic [HIST_BITS-1:0] EDGE_MASK    = 16'b1111000000111111;
    localparam logic [HIST_BITS-1:0] RISE_PATTERN = 16'b0000000000111111;
    localparam logic [HIST_BITS-1:0] FALL_PATTERN = 16'b1111000000000000;

    localparam logic [FIELD_BITS-1:0] POLARITY_RESET = 6'd31;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_CW_END    = 3'd1;
    localparam logic [2:0] PH_CW_BEGIN  = 3'd2;
    localparam logic [2:0] PH_CW_MID    = 3'd3;
    localparam logic [2:0] PH_CCW_BEGIN = 3'd4;
    localparam logic [2:0] PH_CCW_END   = 3'd5;
    localparam logic [2:0] PH_CCW_MID   = 3'd6;

    typedef struct packed {
        logic right;
        logic left;
    } step_t;

    typedef struct packed {
        logic [2:0] phase;
        step_t      step;
    } enc_entry_t;

    function automatic enc_entry_t enc_next(input logic [2:0] phase, input logic [1:0] col);
        enc_entry_t e;
        e.phase = PH_IDLE;
        e.step  = '0;
        case (phase)
            PH_CW_END:
            begin
                case (col)
                    2'd0:    e.phase = PH_CW_MID;
                    2'd1:    e.phase = PH_IDLE;
                    2'd2:    e.phase = PH_CW_END;
                    default: e.step.right = 1'b1;
                endcase
            end
            PH_CW_BEGIN:
            begin
                case (col)
                    2'd0:    e.phase = PH_CW_MID;
                    2'd1:    e.phase = PH_CW_BEGIN;
                    default: e.phase = PH_IDLE;
                endcase
            end
            PH_CW_MID:
            begin
                case (col)
                    2'd0:    e.phase = PH_CW_MID;
                    2'd1:    e.phase = PH_CW_BEGIN;
                    2'd2:    e.phase = PH_CW_END;
                    default: e.phase = PH_IDLE;
                endcase
            end
            PH_CCW_BEGIN:
            begin
                case (col)
                    2'd0:    e.phase = PH_CCW_MID;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_IDLE;
                endcase
            end
            PH_CCW_END:
            begin
                case (col)
                    2'd0:    e.phase = PH_CCW_MID;
                    2'd1:    e.phase = PH_CCW_END;
                    2'd2:    e.phase = PH_IDLE;
                    default: e.step.left = 1'b1;
                endcase
            end
            PH_CCW_MID:
            begin
                case (col)
                    2'd0:    e.phase = PH_CCW_MID;
                    2'd1:    e.phase = PH_CCW_END;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_IDLE;
                endcase
            end
            default:
            begin
                case (col)
                    2'd1:    e.phase = PH_CW_BEGIN;
                    2'd2:    e.phase = PH_CCW_BEGIN;
                    default: e.phase = PH_IDLE;
                endcase
            end
        endcase
        return e;
    endfunction

endpackage

// File: hdl/brs_enc.sv
module brs_enc
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          rot_a,
    input  logic          rot_b,
    output brs_pkg::step_t step
);

    logic [2:0]          phase_reg;
    brs_pkg::enc_entry_t entry;

    assign entry = brs_pkg::enc_next(phase_reg, {rot_a, rot_b});
    assign step  = entry.step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= brs_pkg::PH_IDLE;
        end
        else if (adv)
        begin
            phase_reg <= entry.phase;
        end
    end

endmodule

// File: hdl/brs_btn.sv
module brs_btn
#(
    parameter int NUM_BUTTONS = 6
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           cfg_we,
    input  logic [brs_pkg::FIELD_BITS-1:0] cfg_data,
    input  logic [brs_pkg::FIELD_BITS-1:0] levels,
    output logic [brs_pkg::FIELD_BITS-1:0] events
);

    localparam int HB = brs_pkg::HIST_BITS;

    logic [brs_pkg::FIELD_BITS-1:0] polarity_reg;
    logic [NUM_BUTTONS-1:0]         hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg <= brs_pkg::POLARITY_RESET;
        end
        else if (cfg_we)
        begin
            polarity_reg <= cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++)
        begin : g_btn
            logic          pol;
            logic          lvl;
            logic          pol_rst;
            logic          btn_hit;
            logic [HB-1:0] shifted;
            logic [HB-1:0] hist_reg;
            logic [HB-1:0] hist_next;

            if (g < brs_pkg::FIELD_BITS)
            begin : g_wired
                assign pol     = polarity_reg[g];
                assign lvl     = levels[g];
                assign pol_rst = brs_pkg::POLARITY_RESET[g];
            end
            else
            begin : g_unwired
                assign pol     = 1'b0;
                assign lvl     = 1'b0;
                assign pol_rst = 1'b0;
            end

            assign shifted = {hist_reg[HB-2:0], lvl};
            assign hit[g]  = btn_hit;

            always_comb
            begin
                btn_hit   = 1'b0;
                hist_next = shifted;
                if (pol)
                begin
                    if ((shifted & brs_pkg::EDGE_MASK) == brs_pkg::RISE_PATTERN)
                    begin
                        btn_hit   = 1'b1;
                        hist_next = brs_pkg::HIST_ONES;
                    end
                end
                else
                begin
                    if ((shifted & brs_pkg::EDGE_MASK) == brs_pkg::FALL_PATTERN)
                    begin
                        btn_hit   = 1'b1;
                        hist_next = brs_pkg::HIST_ZEROS;
                    end
                end
            end

            // reload from the new polarity on a register write
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hist_reg <= pol_rst ? brs_pkg::HIST_ZEROS : brs_pkg::HIST_ONES;
                end
                else if (cfg_we)
                begin
                    if (g < brs_pkg::FIELD_BITS)
                    begin
                        hist_reg <= cfg_data[g % brs_pkg::FIELD_BITS] ? brs_pkg::HIST_ZEROS
                                                                      : brs_pkg::HIST_ONES;
                    end
                    else
                    begin
                        hist_reg <= brs_pkg::HIST_ONES;
                    end
                end
                else if (adv)
                begin
                    hist_reg <= hist_next;
                end
            end
        end

        for (g = 0; g < brs_pkg::FIELD_BITS; g++)
        begin : g_evt
            if (g < NUM_BUTTONS)
            begin : g_on
                assign events[g] = hit[g];
            end
            else
            begin : g_off
                assign events[g] = 1'b0;
            end
        end
    endgenerate

endmodule

// File: hdl/button_and_rotary_scanner_core.sv
// Channel   Dir  Beat fields (low bit up)
// s_axis    in   tdata: rot_a[0], rot_b[1], button_levels[7:2]
// m_axis    out  tdata: turn_right[0], turn_left[1], button_events[7:2]
// cfg       in   cfg_data: button_polarity[5:0], written when cfg_we is high
//
// One beat per clock unless stalled; a result appears the cycle after its beat.
// Encoder phase and button histories advance at the input accept edge; the
// result register feeds m_axis. s_axis_tready is high while the result register
// is empty or being drained, so a stalled output holds its beat and stops input.
// Reset: phase neutral, polarity 31, histories reloaded from that polarity.
module button_and_rotary_scanner_core
#(
    parameter int NUM_BUTTONS = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // rot_a, rot_b, button_levels[5:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // turn_right, turn_left, button_events[5:0]
    input  logic       cfg_we,
    input  logic [5:0] cfg_data
);

    logic                           adv;
    brs_pkg::step_t                 step;
    logic [brs_pkg::FIELD_BITS-1:0] events;
    logic                           out_valid_reg;
    logic [7:0]                     out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign adv           = s_axis_tvalid && s_axis_tready;

    brs_enc u_enc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .rot_a (s_axis_tdata[0]),
        .rot_b (s_axis_tdata[1]),
        .step  (step)
    );

    brs_btn #(.NUM_BUTTONS(NUM_BUTTONS)) u_btn
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .levels   (s_axis_tdata[7:2]),
        .events   (events)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {events, step.left, step.right};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: hdl/brs_checker.sv
module brs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       cfg_we,
    input logic [5:0] cfg_data
);

    // an accepted beat always yields a result beat next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat gave no result");

    // empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // one detent step can turn only one way
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("right and left step together");

    // hold a stalled result beat
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

endmodule

bind button_and_rotary_scanner_core brs_checker u_brs_checker (.*);

// File: bench/brs_scan_checker.sv
`timescale 1ns / 100ps

module brs_scan_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    output int         mismatches,
    output int         pending_scans
);

    typedef struct packed {
        logic [brs_pkg::FIELD_BITS-1:0] levels;
        logic                           rot_b;
        logic                           rot_a;
    } scan_beat_t;

    typedef struct packed {
        logic [brs_pkg::FIELD_BITS-1:0] events;
        logic                           turn_left;
        logic                           turn_right;
    } scan_result_t;

    logic [2:0]                     enc_phase;
    logic [brs_pkg::FIELD_BITS-1:0] polarity;
    logic [brs_pkg::HIST_BITS-1:0]  history [brs_pkg::FIELD_BITS];
    scan_result_t                   expected_scans [$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void reload_history();
        for (int i = 0; i < brs_pkg::FIELD_BITS; i++)
            history[i] = polarity[i] ? brs_pkg::HIST_ZEROS : brs_pkg::HIST_ONES;
    endfunction

    function automatic scan_result_t predict_scan(input scan_beat_t beat);
        scan_result_t                  res;
        logic [1:0]                    col;
        logic [2:0]                    nxt;
        logic [brs_pkg::HIST_BITS-1:0] h;
        res = '0;
        col = {beat.rot_a, beat.rot_b};
        nxt = brs_pkg::PH_IDLE;
        case (enc_phase)
            brs_pkg::PH_CW_END:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CW_MID;
                else if (col == 2'd2)
                    nxt = brs_pkg::PH_CW_END;
                else if (col == 2'd3)
                    res.turn_right = 1'b1;
            end
            brs_pkg::PH_CW_BEGIN:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CW_MID;
                else if (col == 2'd1)
                    nxt = brs_pkg::PH_CW_BEGIN;
            end
            brs_pkg::PH_CW_MID:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CW_MID;
                else if (col == 2'd1)
                    nxt = brs_pkg::PH_CW_BEGIN;
                else if (col == 2'd2)
                    nxt = brs_pkg::PH_CW_END;
            end
            brs_pkg::PH_CCW_BEGIN:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CCW_MID;
                else if (col == 2'd2)
                    nxt = brs_pkg::PH_CCW_BEGIN;
            end
            brs_pkg::PH_CCW_END:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CCW_MID;
                else if (col == 2'd1)
                    nxt = brs_pkg::PH_CCW_END;
                else if (col == 2'd3)
                    res.turn_left = 1'b1;
            end
            brs_pkg::PH_CCW_MID:
            begin
                if (col == 2'd0)
                    nxt = brs_pkg::PH_CCW_MID;
                else if (col == 2'd1)
                    nxt = brs_pkg::PH_CCW_END;
                else if (col == 2'd2)
                    nxt = brs_pkg::PH_CCW_BEGIN;
            end
            default:
            begin
                // neutral, and the unused code behaves the same
                if (col == 2'd1)
                    nxt = brs_pkg::PH_CW_BEGIN;
                else if (col == 2'd2)
                    nxt = brs_pkg::PH_CCW_BEGIN;
            end
        endcase
        enc_phase = nxt;

        for (int i = 0; i < brs_pkg::FIELD_BITS; i++)
        begin
            h = {history[i][brs_pkg::HIST_BITS-2:0], beat.levels[i]};
            if (polarity[i] && (h & brs_pkg::EDGE_MASK) == brs_pkg::RISE_PATTERN)
            begin
                h = brs_pkg::HIST_ONES;
                res.events[i] = 1'b1;
            end
            else if (!polarity[i] && (h & brs_pkg::EDGE_MASK) == brs_pkg::FALL_PATTERN)
            begin
                h = brs_pkg::HIST_ZEROS;
                res.events[i] = 1'b1;
            end
            history[i] = h;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t got;
        scan_result_t want;
        if (!rst_n)
        begin
            enc_phase = brs_pkg::PH_IDLE;
            polarity  = brs_pkg::POLARITY_RESET;
            reload_history();
            expected_scans.delete();
            mismatches = 0;
            pending_scans <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_scans.size() == 0)
                    report_mismatch("unexpected result beat", got, 8'h00);
                else
                begin
                    want = expected_scans.pop_front();
                    if (got.turn_right !== want.turn_right)
                        report_mismatch("turn_right", 8'(got.turn_right),
                                        8'(want.turn_right));
                    if (got.turn_left !== want.turn_left)
                        report_mismatch("turn_left", 8'(got.turn_left),
                                        8'(want.turn_left));
                    if (got.events !== want.events)
                        report_mismatch("button_events", 8'(got.events),
                                        8'(want.events));
                end
            end
            if (cfg_we)
            begin
                polarity = cfg_data;
                reload_history();
            end
            if (s_tvalid && s_tready)
                expected_scans.push_back(predict_scan(s_tdata));
            pending_scans <= expected_scans.size();
        end
    end

endmodule

// File: bench/tb_button_and_rotary_scanner_core.sv
`timescale 1ns / 100ps

module tb_button_and_rotary_scanner_core;

    localparam int NUM_BTN       = 6;
    localparam int RAND_PHASES   = 8;
    localparam int BEATS_PER_RUN = 150;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 200000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       cfg_we = 1'b0;
    logic [5:0] cfg_data = 6'h00;

    int mismatches;
    int pending_scans;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int cycle_count = 0;

    logic [1:0]         enc_cols [$];
    logic [NUM_BTN-1:0] btn_level = '0;
    int                 btn_run [NUM_BTN];

    button_and_rotary_scanner_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    brs_scan_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending_scans (pending_scans)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // column is {rot_a, rot_b}
    function automatic logic [7:0] pack_beat(input logic [1:0] col, input logic [5:0] levels);
        return {levels, col[0], col[1]};
    endfunction

    function automatic void queue_encoder_motion();
        int         pick;
        int         len;
        logic       ccw;
        logic [1:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            ccw = 1'($urandom_range(0, 1));
            len = (pick < 65) ? 4 : $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                col = (i == 0) ? 2'd1 : (i == 1) ? 2'd0 : (i == 2) ? 2'd2 : 2'd3;
                // swap the pins for the opposite direction
                if (ccw)
                    col = {col[0], col[1]};
                repeat ($urandom_range(1, 3)) enc_cols.push_back(col);
            end
            repeat ($urandom_range(0, 3)) enc_cols.push_back(2'd3);
        end
        else
            repeat ($urandom_range(1, 4)) enc_cols.push_back(2'($urandom_range(0, 3)));
    endfunction

    function automatic logic [5:0] next_button_levels();
        logic [5:0] lv;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            if (btn_run[i] == 0)
            begin
                btn_level[i] = ~btn_level[i];
                btn_run[i] = $urandom_range(1, 16);
            end
            else
                btn_run[i]--;
        end
        lv = btn_level;
        // bounce one contact now and then
        if ($urandom_range(0, 99) < 10)
            lv[3'($urandom_range(0, NUM_BTN - 1))] ^= 1'b1;
        if ($urandom_range(0, 99) < 5)
            lv = 6'($urandom_range(0, 63));
        return lv;
    endfunction

    function automatic logic [7:0] make_scan_beat();
        if (enc_cols.size() == 0)
            queue_encoder_motion();
        return pack_beat(enc_cols.pop_front(), next_button_levels());
    endfunction

    task automatic send_beat(input logic [7:0] beat);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_scans != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_polarity(input logic [5:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [1:0] dir_cols [16];
        logic [5:0] dir_levels [16];
        logic [5:0] pol;

        // right detent, left detent, aborted turn, rest and stray columns
        dir_cols = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                     2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd3, 2'd2, 2'd3};
        // rising edges on active-high buttons, then falling edge on the active-low one
        dir_levels = '{6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F,
                       6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
                       6'h2A, 6'h15, 6'h3F, 6'h00};
        for (int i = 0; i < NUM_BTN; i++)
            btn_run[i] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++)
            send_beat(pack_beat(dir_cols[i], dir_levels[i]));
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1:       begin tx_idle_pct = 67; rx_stall_pct <= 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct <= 67; end
                default: begin tx_idle_pct = 8;  rx_stall_pct <= 8;  end
            endcase
            case (ph)
                0:       pol = 6'h3F;
                1:       pol = 6'h00;
                2:       pol = 6'h2A;
                3:       pol = 6'h15;
                6:       pol = 6'h00;
                7:       pol = 6'h3F;
                default: pol = 6'($urandom_range(0, 63));
            endcase
            write_polarity(pol);
            for (int n = 0; n < BEATS_PER_RUN; n++)
                send_beat(make_scan_beat());
            drain_results();
        end

        @(negedge clk);
        if (mismatches == 0 && pending_scans == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hdl/brs_pkg.sv
hdl/brs_enc.sv
hdl/brs_btn.sv
hdl/button_and_rotary_scanner_core.sv
hdl/brs_checker.sv
bench/brs_scan_checker.sv
bench/tb_button_and_rotary_scanner_core.sv
